// File: sv/tqas_pkg.sv
// Shared constants, codes and types for the annealing swap block.
package tqas_pkg;

  localparam int SLICES_MAX = 16;
  localparam int CITIES_MAX = 32;
  localparam int SLICE_W    = $clog2(SLICES_MAX);
  localparam int CITY_W     = $clog2(CITIES_MAX);
  localparam int SCNT_W     = 5;
  localparam int CCNT_W     = 6;
  localparam int ROW_W      = SLICE_W + CITY_W;
  localparam int SPIN_ROWS  = SLICES_MAX * CITIES_MAX;
  localparam int DIST_AW    = 2 * CITY_W;
  localparam int DIST_DEPTH = CITIES_MAX * CITIES_MAX;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int ACC_W      = 24;
  localparam int NUM_W      = ACC_W + 18;
  localparam int DEN_W      = 20;
  localparam int DIV_CW     = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {
    ACT_DIST = 2'd0,
    ACT_SPIN = 2'd1,
    ACT_SWAP = 2'd2,
    ACT_BAD  = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLICES = 2'd0,
    CFG_CITIES = 2'd1,
    CFG_DSCALE = 2'd2,
    CFG_BETA   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: sv/tqas_if.sv
// Input and result channel interfaces.
interface tqas_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [3:0]         slice_index;
  logic [4:0]         first_index;
  logic [4:0]         second_index;
  logic [15:0]        distance_value;
  logic               spin_value;
  logic signed [15:0] log_random;
  logic signed [15:0] quantum_gain;

  modport source (output valid, action, slice_index, first_index, second_index,
                  distance_value, spin_value, log_random, quantum_gain,
                  input ready);
  modport sink   (input valid, action, slice_index, first_index, second_index,
                  distance_value, spin_value, log_random, quantum_gain,
                  output ready);
endinterface

interface tqas_out_if;
  logic               valid;
  logic               ready;
  logic               flipped;
  logic signed [31:0] energy_change;
  logic               status;

  modport source (output valid, flipped, energy_change, status, input ready);
  modport sink   (input valid, flipped, energy_change, status, output ready);
endinterface

// File: sv/tqas_div.sv
// Restoring divider, one quotient bit per cycle.
module tqas_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tqas_pkg::div_req_t req_i,
  output tqas_pkg::div_rsp_t rsp_o
);
  import tqas_pkg::*;

  logic [DEN_W-1:0]  rem_q, den_q;
  logic [NUM_W-1:0]  wq_q;
  logic [DIV_CW-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DEN_W:0]    shifted, diff;
  logic              ge;

  assign shifted = {rem_q, wq_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      den_q  <= '0;
      wq_q   <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= '0;
        wq_q   <= req_i.num;
        den_q  <= req_i.den;
        cnt_q  <= DIV_CW'(NUM_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        wq_q  <= {wq_q[NUM_W-2:0], ge};
        cnt_q <= cnt_q - DIV_CW'(1);
        if (cnt_q == DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = wq_q;

endmodule

// File: sv/tsp_quantum_anneal_swap.sv
// Top level: annealing swap move engine with spin and distance stores.
//
//  channel   dir  payload                                           handshake
//  in_ch     in   action, slice/first/second index, distance,       valid/ready
//                 spin, log_random, quantum_gain
//  out_ch    out  flipped, energy_change, status                    valid/ready
//  cfg       in   cfg_idx_i, cfg_data_i                             cfg_we_i
//
// A swap trial runs a ten-row scan of the spin store, then reads one distance
// pair per cycle from the two-port table, then runs a 42-step divider, the
// cost, multiply and decide steps and, if taken, the spin flip. One transaction
// at a time; ready is low while a trial runs. Stores are not cleared by reset.
module tsp_quantum_anneal_swap (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tqas_in_if.sink                        in_ch,
  tqas_out_if.source                     out_ch,
  input  logic                           cfg_we_i,
  input  logic [tqas_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tqas_pkg::CFG_W-1:0]     cfg_data_i
);
  import tqas_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ROWS, S_DIST, S_DIV, S_COST, S_MUL, S_DECIDE, S_FLIP, S_DONE
  } state_e;

  localparam logic [CCNT_W-1:0] ROW_LAST  = CCNT_W'(10);
  localparam logic [CCNT_W-1:0] FLIP_LAST = CCNT_W'(3);
  localparam logic signed [43:0] SAT_MAX = 44'sd2147483647;
  localparam logic signed [43:0] SAT_MIN = -44'sd2147483648;

  // Highest city with a +1 spin among those in use.
  function automatic logic [CITY_W:0] hi_city(logic [CITIES_MAX-1:0] row,
                                              logic [CCNT_W-1:0] n);
    logic              found;
    logic [CITY_W-1:0] idx;
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < CITIES_MAX; i++) begin
      if (row[i] && (CCNT_W'(i) < n)) begin
        found = 1'b1;
        idx   = CITY_W'(i);
      end
    end
    return {found, idx};
  endfunction

  state_e              state_q;
  logic [SCNT_W-1:0]   slice_cnt_q;
  logic [CCNT_W-1:0]   city_cnt_q;
  logic [15:0]         dscale_q, beta_q;

  logic [SLICE_W-1:0]  tr_q;
  logic [CITY_W-1:0]   a_q, b_q, p_q, q_k;
  logic                fp_q, fq_q;
  logic signed [15:0]  lr_q, qg_q;
  logic [CCNT_W-1:0]   cnt_q;
  logic signed [2:0]   g_q [CITIES_MAX];
  logic signed [3:0]   m_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [31:0]  cost_q;
  logic signed [48:0]  prod_q;
  logic                res_flip_q, res_stat_q;
  logic                out_valid_q, out_flip_q, out_stat_q;
  logic signed [31:0]  out_cost_q;

  // effective configuration
  logic [SCNT_W-1:0]   nt_eff;
  logic [CCNT_W-1:0]   ns_eff;
  logic [15:0]         dsc_eff;
  logic [DEN_W-1:0]    den;

  always_comb begin
    nt_eff = slice_cnt_q;
    if (slice_cnt_q == '0) nt_eff = SCNT_W'(1);
    if (slice_cnt_q > SCNT_W'(SLICES_MAX)) nt_eff = SCNT_W'(SLICES_MAX);
    ns_eff = city_cnt_q;
    if (city_cnt_q < CCNT_W'(3)) ns_eff = CCNT_W'(3);
    if (city_cnt_q > CCNT_W'(CITIES_MAX)) ns_eff = CCNT_W'(CITIES_MAX);
    dsc_eff = (dscale_q == '0) ? 16'd1 : dscale_q;
  end

  assign den = DEN_W'(dsc_eff * nt_eff);

  // input checks
  logic    in_acc, t_ok, a_ok, b_ok;
  action_e act_in;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign act_in = action_e'(in_ch.action);
  assign t_ok   = {1'b0, in_ch.slice_index} < nt_eff;
  assign a_ok   = {1'b0, in_ch.first_index} < ns_eff;
  assign b_ok   = {1'b0, in_ch.second_index} < ns_eff;

  // wrapped neighbours
  logic [CITY_W-1:0]  am, ap, bm, bp;
  logic [SLICE_W-1:0] tm, tp;

  assign am = (a_q == '0) ? CITY_W'(ns_eff - CCNT_W'(1)) : a_q - CITY_W'(1);
  assign ap = ({1'b0, a_q} + CCNT_W'(1) == ns_eff) ? '0 : a_q + CITY_W'(1);
  assign bm = (b_q == '0) ? CITY_W'(ns_eff - CCNT_W'(1)) : b_q - CITY_W'(1);
  assign bp = ({1'b0, b_q} + CCNT_W'(1) == ns_eff) ? '0 : b_q + CITY_W'(1);
  assign tm = (tr_q == '0) ? SLICE_W'(nt_eff - SCNT_W'(1)) : tr_q - SLICE_W'(1);
  assign tp = ({1'b0, tr_q} + SCNT_W'(1) == nt_eff) ? '0 : tr_q + SLICE_W'(1);

  // spin store: one row per slice and position, one bit per city
  logic [CITIES_MAX-1:0] spin_mem [SPIN_ROWS];
  logic [CITIES_MAX-1:0] spin_rd_q;
  logic [ROW_W-1:0]      row_addr, spin_wrow;
  logic [CITY_W-1:0]     spin_wbit;
  logic                  spin_we, spin_wval;
  logic [3:0]            rd_idx;

  always_comb begin
    case (cnt_q[3:0])
      4'd0:    row_addr = {tr_q, a_q};
      4'd1:    row_addr = {tr_q, b_q};
      4'd2:    row_addr = {tr_q, am};
      4'd3:    row_addr = {tr_q, ap};
      4'd4:    row_addr = {tr_q, bm};
      4'd5:    row_addr = {tr_q, bp};
      4'd6:    row_addr = {tm, a_q};
      4'd7:    row_addr = {tp, a_q};
      4'd8:    row_addr = {tm, b_q};
      4'd9:    row_addr = {tp, b_q};
      default: row_addr = {tr_q, a_q};
    endcase
  end

  assign rd_idx = cnt_q[3:0] - 4'd1;

  always_comb begin
    spin_we   = 1'b0;
    spin_wrow = {in_ch.slice_index, in_ch.first_index};
    spin_wbit = in_ch.second_index;
    spin_wval = in_ch.spin_value;
    if (state_q == S_IDLE) begin
      spin_we = in_acc && (act_in == ACT_SPIN) && t_ok && a_ok && b_ok;
    end else if (state_q == S_FLIP) begin
      // order matters when both positions hold the same city
      spin_we = 1'b1;
      case (cnt_q[1:0])
        2'd0:    begin spin_wrow = {tr_q, a_q}; spin_wbit = p_q; spin_wval = 1'b0; end
        2'd1:    begin spin_wrow = {tr_q, a_q}; spin_wbit = q_k; spin_wval = 1'b1; end
        2'd2:    begin spin_wrow = {tr_q, b_q}; spin_wbit = p_q; spin_wval = 1'b1; end
        default: begin spin_wrow = {tr_q, b_q}; spin_wbit = q_k; spin_wval = 1'b0; end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (spin_we) spin_mem[spin_wrow][spin_wbit] <= spin_wval;
    spin_rd_q <= spin_mem[row_addr];
  end

  // distance table, two read ports for the p and q rows
  logic [15:0]        dist_mem [DIST_DEPTH];
  logic [15:0]        dq_rd_q, dp_rd_q;
  logic               dist_we;

  assign dist_we = (state_q == S_IDLE) && in_acc && (act_in == ACT_DIST) && a_ok && b_ok;

  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[{in_ch.first_index, in_ch.second_index}] <= in_ch.distance_value;
    dq_rd_q <= dist_mem[{q_k, cnt_q[CITY_W-1:0]}];
    dp_rd_q <= dist_mem[{p_q, cnt_q[CITY_W-1:0]}];
  end

  // scan helpers
  logic [CITY_W:0]         hit;
  logic                    bit_p, bit_q;
  logic signed [16:0]      ddiff;
  logic signed [2:0]       gsel;
  logic signed [ACC_W-1:0] term;

  assign hit   = hi_city(spin_rd_q, ns_eff);
  assign bit_p = spin_rd_q[p_q];
  assign bit_q = spin_rd_q[q_k];
  assign ddiff = $signed({1'b0, dq_rd_q}) - $signed({1'b0, dp_rd_q});
  assign gsel  = g_q[CITY_W'(cnt_q - CCNT_W'(1))];

  always_comb begin
    case (gsel)
      3'sd1:   term = ACC_W'(ddiff);
      3'sd2:   term = ACC_W'(ddiff) <<< 1;
      -3'sd1:  term = -ACC_W'(ddiff);
      -3'sd2:  term = -(ACC_W'(ddiff) <<< 1);
      default: term = '0;
    endcase
  end

  // divider
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [ACC_W-1:0]  mag;

  assign mag           = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign div_req.start = (state_q == S_DIV) && (cnt_q == '0);
  assign div_req.num   = {mag, 18'd0};
  assign div_req.den   = den;

  tqas_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // cost assembly and acceptance
  logic signed [42:0] qs;
  logic signed [19:0] qm;
  logic signed [43:0] total;
  logic signed [31:0] cost_sat;
  logic signed [16:0] beta_s;
  logic signed [49:0] lhs50, rhs50;
  logic               take;

  assign qs     = acc_q[ACC_W-1] ? -$signed({1'b0, div_rsp.quot})
                                 : $signed({1'b0, div_rsp.quot});
  assign qm     = qg_q * m_q;
  assign total  = 44'(qs) + (44'(qm) <<< 9);
  assign beta_s = $signed({1'b0, beta_q});
  assign lhs50  = 50'($signed({lr_q, 16'h0000}));
  assign rhs50  = -50'(prod_q);
  assign take   = (cost_q <= 32'sd0) || (lhs50 < rhs50);

  always_comb begin
    if (total > SAT_MAX)      cost_sat = 32'sh7fffffff;
    else if (total < SAT_MIN) cost_sat = 32'sh80000000;
    else                      cost_sat = 32'(total);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slice_cnt_q <= SCNT_W'(16);
      city_cnt_q  <= CCNT_W'(32);
      dscale_q    <= 16'hffff;
      beta_q      <= 16'd256;
      tr_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      p_q         <= '0;
      q_k         <= '0;
      fp_q        <= 1'b0;
      fq_q        <= 1'b0;
      lr_q        <= '0;
      qg_q        <= '0;
      cnt_q       <= '0;
      for (int i = 0; i < CITIES_MAX; i++) g_q[i] <= '0;
      m_q         <= '0;
      acc_q       <= '0;
      cost_q      <= '0;
      prod_q      <= '0;
      res_flip_q  <= 1'b0;
      res_stat_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_flip_q  <= 1'b0;
      out_stat_q  <= 1'b0;
      out_cost_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SLICES: slice_cnt_q <= cfg_data_i[SCNT_W-1:0];
          CFG_CITIES: city_cnt_q  <= cfg_data_i[CCNT_W-1:0];
          CFG_DSCALE: dscale_q    <= cfg_data_i;
          CFG_BETA:   beta_q      <= cfg_data_i;
          default:    ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            tr_q       <= in_ch.slice_index;
            a_q        <= in_ch.first_index;
            b_q        <= in_ch.second_index;
            lr_q       <= in_ch.log_random;
            qg_q       <= in_ch.quantum_gain;
            cnt_q      <= '0;
            fp_q       <= 1'b0;
            fq_q       <= 1'b0;
            m_q        <= '0;
            acc_q      <= '0;
            cost_q     <= '0;
            res_flip_q <= 1'b0;
            for (int i = 0; i < CITIES_MAX; i++) g_q[i] <= '0;
            state_q    <= S_DONE;
            case (act_in)
              ACT_DIST: res_stat_q <= !(a_ok && b_ok);
              ACT_SPIN: res_stat_q <= !(t_ok && a_ok && b_ok);
              ACT_SWAP: begin
                if (!(t_ok && a_ok && b_ok)) begin
                  res_stat_q <= 1'b1;
                end else begin
                  res_stat_q <= 1'b0;
                  // equal positions: null move
                  if (in_ch.first_index != in_ch.second_index) state_q <= S_ROWS;
                end
              end
              default: res_stat_q <= 1'b1;
            endcase
          end
        end
        S_ROWS: begin
          cnt_q <= cnt_q + CCNT_W'(1);
          if (cnt_q != '0) begin
            case (rd_idx)
              4'd0: begin fp_q <= hit[CITY_W]; p_q <= hit[CITY_W-1:0]; end
              4'd1: begin fq_q <= hit[CITY_W]; q_k <= hit[CITY_W-1:0]; end
              4'd2, 4'd3: begin
                for (int i = 0; i < CITIES_MAX; i++)
                  if (spin_rd_q[i]) g_q[i] <= g_q[i] + 3'sd1;
              end
              4'd4, 4'd5: begin
                for (int i = 0; i < CITIES_MAX; i++)
                  if (spin_rd_q[i]) g_q[i] <= g_q[i] - 3'sd1;
              end
              4'd6, 4'd7: m_q <= m_q + $signed({3'b000, bit_p}) - $signed({3'b000, bit_q});
              4'd8, 4'd9: m_q <= m_q + $signed({3'b000, bit_q}) - $signed({3'b000, bit_p});
              default: ;
            endcase
          end
          if (cnt_q == ROW_LAST) begin
            cnt_q <= '0;
            if (fp_q && fq_q) begin
              state_q <= S_DIST;
            end else begin
              res_stat_q <= 1'b1;
              state_q    <= S_DONE;
            end
          end
        end
        S_DIST: begin
          cnt_q <= cnt_q + CCNT_W'(1);
          if (cnt_q != '0) acc_q <= acc_q + term;
          if (cnt_q == ns_eff) begin
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_q == '0) cnt_q <= CCNT_W'(1);
          else if (div_rsp.done) state_q <= S_COST;
        end
        S_COST: begin
          cost_q  <= cost_sat;
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q  <= beta_s * cost_q;
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          cnt_q <= '0;
          if (take) begin
            res_flip_q <= 1'b1;
            state_q    <= S_FLIP;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_FLIP: begin
          cnt_q <= cnt_q + CCNT_W'(1);
          if (cnt_q == FLIP_LAST) state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ch.ready) begin
            out_valid_q <= 1'b1;
            out_flip_q  <= res_flip_q;
            out_stat_q  <= res_stat_q;
            out_cost_q  <= cost_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready          = (state_q == S_IDLE);
  assign out_ch.valid         = out_valid_q;
  assign out_ch.flipped       = out_flip_q;
  assign out_ch.energy_change = out_cost_q;
  assign out_ch.status        = out_stat_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("ready high in cycle after accept");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.status |-> (out_ch.energy_change == '0) && !out_ch.flipped)
    else $error("error result carries cost or flip");

  a_flip_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FLIP |-> res_flip_q && (cnt_q <= FLIP_LAST))
    else $error("spin flip without accepted move");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside divide step");
`endif

endmodule
